[src/rtmc_pkg.sv]
// ----------------------------------------------------------------------------
// rtmc_pkg
// Shared types, constants and helpers of the traversal request coalescer.
// ----------------------------------------------------------------------------
package rtmc_pkg;

    localparam int THREADS_DEF     = 32;
    localparam int FIFO_DEPTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 32;

    localparam int ENTRY_W = 51;   // kind | size | addr
    localparam int CFG_REGS = 4;
    localparam int PADDR_W = 4;
    localparam logic [15:0] DELAY_MAX = 16'hFFFF;

    // Access kinds with a programmable latency
    localparam logic [2:0] KIND_INTERNAL = 3'd1;
    localparam logic [2:0] KIND_INSTANCE = 3'd2;
    localparam logic [2:0] KIND_QUAD     = 3'd4;
    localparam logic [2:0] KIND_QUAD_HIT = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_INTERNAL = 2'd0;
    localparam logic [1:0] REG_INSTANCE = 2'd1;
    localparam logic [1:0] REG_QUAD     = 2'd2;
    localparam logic [1:0] REG_QUAD_HIT = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_SCHED = 2'd1,
        OP_RESP  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_HEAD,
        S_QCMP,
        S_ISSUE,
        S_ISSUE_RD,
        S_TICK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  thread;
        logic [31:0] addr;
        logic [15:0] size;
        logic [2:0]  kind;
    } in_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        req_valid;
        logic [31:0] req_addr;
        logic [15:0] req_size;
        logic [2:0]  req_kind;
        logic [5:0]  thread_count;
        logic        stalled;
        logic        delays_done;
        logic [5:0]  active_count;
    } out_rsp_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        op_t         op;
        logic        in_range;
        logic [4:0]  thread;
        logic [31:0] addr;
        logic [15:0] size;
        logic [2:0]  kind;
    } work_t;

    typedef struct packed {
        logic [7:0] internal_lat;
        logic [7:0] instance_lat;
        logic [7:0] quad_lat;
        logic [7:0] quad_hit_lat;
    } cfg_t;

    function automatic logic [7:0] kind_latency(input logic [2:0] kind, input cfg_t cfg);
        logic [7:0] lat;
        case (kind)
            KIND_INTERNAL: lat = cfg.internal_lat;
            KIND_INSTANCE: lat = cfg.instance_lat;
            KIND_QUAD:     lat = cfg.quad_lat;
            KIND_QUAD_HIT: lat = cfg.quad_hit_lat;
            default:       lat = 8'd1;
        endcase
        return lat;
    endfunction

endpackage

[src/rtmc_ram.sv]
// ----------------------------------------------------------------------------
// rtmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rtmc_front.sv]
// ----------------------------------------------------------------------------
// rtmc_front
// Accepts requests, decodes them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module rtmc_front #(
    parameter int THREADS = rtmc_pkg::THREADS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rtmc_pkg::in_req_t item,
    output logic             work_valid,
    input  logic             work_take,
    output rtmc_pkg::work_t  work
);

    rtmc_pkg::work_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push;
    logic            pop;
    rtmc_pkg::work_t dec;

    assign item_stall = (cnt_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign work_valid = (cnt_reg != 2'd0);
    assign pop        = work_valid && work_take;
    assign work       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        dec.op       = rtmc_pkg::op_t'(item.action);
        dec.in_range = (32'(item.thread) < THREADS);
        dec.thread   = item.thread;
        dec.addr     = item.addr;
        dec.size     = item.size;
        dec.kind     = item.kind;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/rtmc_back.sv]
// ----------------------------------------------------------------------------
// rtmc_back
// Sequencer that carries out each request; all but a push walk the threads one at a time.
// ----------------------------------------------------------------------------
module rtmc_back #(
    parameter int THREADS     = rtmc_pkg::THREADS_DEF,
    parameter int FIFO_DEPTH  = rtmc_pkg::FIFO_DEPTH_DEF,
    parameter int QUEUE_DEPTH = rtmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rtmc_pkg::cfg_t    cfg,
    input  logic              work_valid,
    output logic              work_take,
    input  rtmc_pkg::work_t   work,
    output logic              result_valid,
    input  logic              result_stall,
    output rtmc_pkg::out_rsp_t result
);

    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW  = $clog2(THREADS + 1);
    localparam int HW  = $clog2(FIFO_DEPTH);
    localparam int FW  = $clog2(FIFO_DEPTH + 1);
    localparam int AW  = $clog2(THREADS * FIFO_DEPTH);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QFW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = rtmc_pkg::ENTRY_W;

    rtmc_pkg::state_t state_reg, state_next;
    rtmc_pkg::work_t  item_reg, item_next;
    logic [TW-1:0]    t_reg, t_next;
    logic [QFW-1:0]   q_idx_reg, q_idx_next;
    logic [QAW-1:0]   qhead_reg, qhead_next;
    logic [QFW-1:0]   pfill_reg, pfill_next;
    logic [EW-1:0]    pair_reg, pair_next;
    logic [1:0]       status_reg, status_next;
    logic [5:0]       count_reg, count_next;
    logic             req_valid_reg, req_valid_next;
    logic [EW-1:0]    req_reg, req_next;

    logic [FW-1:0]    fill_reg  [THREADS];
    logic [HW-1:0]    head_reg  [THREADS];
    logic [15:0]      delay_reg [THREADS];
    logic             mark_reg  [THREADS];
    logic [CW-1:0]    active_cnt_reg, active_cnt_next;
    logic [CW-1:0]    busy_cnt_reg, busy_cnt_next;
    logic [CW-1:0]    ready_cnt_reg, ready_cnt_next;

    logic             out_valid_reg, out_valid_next;
    rtmc_pkg::out_rsp_t out_reg, out_next;

    // current thread and its update
    logic [TW-1:0]    cur;
    logic [FW-1:0]    cur_fill;
    logic [HW-1:0]    cur_head;
    logic [15:0]      cur_delay;
    logic             cur_mark;
    logic             thr_we;
    logic [FW-1:0]    fill_n;
    logic [HW-1:0]    head_n;
    logic [15:0]      delay_n;
    logic             mark_n;
    logic             cur_ready;
    logic             last_t;
    logic             slot_free;

    // memories
    logic             arm_we;
    logic [AW-1:0]    arm_waddr, arm_raddr;
    logic [EW-1:0]    arm_wdata, arm_rdata;
    logic             qrm_we;
    logic [QAW-1:0]   qrm_waddr, qrm_raddr;
    logic [EW-1:0]    qrm_wdata, qrm_rdata;

    logic [HW:0]      slot_sum;
    logic [HW-1:0]    slot;
    logic [16:0]      delay_sum;

    function automatic logic [QAW-1:0] qaddr(input logic [QAW-1:0] base,
                                             input logic [QFW-1:0] off);
        logic [QFW:0] sum;
        sum = (QFW + 1)'(base) + (QFW + 1)'(off);
        if (sum >= (QFW + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (QFW + 1)'(QUEUE_DEPTH);
        end
        return sum[QAW-1:0];
    endfunction

    function automatic logic [AW-1:0] arm_addr(input logic [TW-1:0] t,
                                               input logic [HW-1:0] s);
        return AW'(AW'(t) * AW'(FIFO_DEPTH)) + AW'(s);
    endfunction

    rtmc_ram #(.WIDTH(EW), .DEPTH(THREADS * FIFO_DEPTH)) u_access_ram (
        .clk   (clk),
        .we    (arm_we),
        .waddr (arm_waddr),
        .wdata (arm_wdata),
        .raddr (arm_raddr),
        .rdata (arm_rdata)
    );

    rtmc_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_pending_ram (
        .clk   (clk),
        .we    (qrm_we),
        .waddr (qrm_waddr),
        .wdata (qrm_wdata),
        .raddr (qrm_raddr),
        .rdata (qrm_rdata)
    );

    assign cur       = (state_reg == rtmc_pkg::S_PUSH) ? item_reg.thread[TW-1:0] : t_reg;
    assign cur_fill  = fill_reg[cur];
    assign cur_head  = head_reg[cur];
    assign cur_delay = delay_reg[cur];
    assign cur_mark  = mark_reg[cur];
    assign cur_ready = (cur_fill != '0) && (cur_delay == 16'd0) && !cur_mark;
    assign last_t    = (32'(t_reg) == THREADS - 1);
    assign slot_free = !out_valid_reg || !result_stall;

    assign slot_sum  = (HW + 1)'(cur_head) + (HW + 1)'(cur_fill);
    assign slot      = (slot_sum >= (HW + 1)'(FIFO_DEPTH)) ?
                       HW'(slot_sum - (HW + 1)'(FIFO_DEPTH)) : slot_sum[HW-1:0];
    assign delay_sum = {1'b0, cur_delay} +
                       17'(rtmc_pkg::kind_latency(arm_rdata[50:48], cfg));

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtmc_pkg::S_IDLE:
            begin
                if (work_valid)
                begin
                    case (work.op)
                        rtmc_pkg::OP_PUSH: state_next = rtmc_pkg::S_PUSH;
                        rtmc_pkg::OP_TICK: state_next = rtmc_pkg::S_TICK;
                        default:           state_next = rtmc_pkg::S_SCAN;
                    endcase
                end
            end
            rtmc_pkg::S_PUSH: state_next = rtmc_pkg::S_FINISH;
            rtmc_pkg::S_SCAN:
            begin
                if ((item_reg.op == rtmc_pkg::OP_SCHED) ? cur_ready : (cur_fill != '0))
                    state_next = rtmc_pkg::S_HEAD;
                else if (last_t)
                    state_next = (item_reg.op == rtmc_pkg::OP_SCHED) ?
                                 rtmc_pkg::S_ISSUE : rtmc_pkg::S_FINISH;
            end
            rtmc_pkg::S_HEAD, rtmc_pkg::S_QCMP:
            begin
                if (state_reg == rtmc_pkg::S_HEAD && item_reg.op == rtmc_pkg::OP_SCHED &&
                    pfill_reg != '0)
                    state_next = rtmc_pkg::S_QCMP;
                else if (state_reg == rtmc_pkg::S_QCMP &&
                         qrm_rdata[47:0] != pair_reg[47:0] &&
                         (q_idx_reg + 1'b1) < pfill_reg)
                    state_next = rtmc_pkg::S_QCMP;
                else if (!last_t)
                    state_next = rtmc_pkg::S_SCAN;
                else
                    state_next = (item_reg.op == rtmc_pkg::OP_SCHED) ?
                                 rtmc_pkg::S_ISSUE : rtmc_pkg::S_FINISH;
            end
            rtmc_pkg::S_ISSUE:
                state_next = (pfill_reg == '0) ? rtmc_pkg::S_FINISH : rtmc_pkg::S_ISSUE_RD;
            rtmc_pkg::S_ISSUE_RD: state_next = rtmc_pkg::S_FINISH;
            rtmc_pkg::S_TICK:
                if (last_t) state_next = rtmc_pkg::S_FINISH;
            rtmc_pkg::S_FINISH:
                if (slot_free) state_next = rtmc_pkg::S_IDLE;
            default: state_next = rtmc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next      = item_reg;
        t_next         = t_reg;
        q_idx_next     = q_idx_reg;
        qhead_next     = qhead_reg;
        pfill_next     = pfill_reg;
        pair_next      = pair_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        work_take      = 1'b0;
        thr_we         = 1'b0;
        fill_n         = cur_fill;
        head_n         = cur_head;
        delay_n        = cur_delay;
        mark_n         = cur_mark;
        arm_we         = 1'b0;
        arm_waddr      = arm_addr(cur, slot);
        arm_wdata      = {item_reg.kind, item_reg.size, item_reg.addr};
        arm_raddr      = arm_addr(cur, cur_head);
        qrm_we         = 1'b0;
        qrm_waddr      = qaddr(qhead_reg, pfill_reg);
        qrm_wdata      = pair_reg;
        qrm_raddr      = qaddr(qhead_reg, '0);

        case (state_reg)
            rtmc_pkg::S_IDLE:
            begin
                work_take = work_valid;
                if (work_valid)
                begin
                    item_next      = work;
                    t_next         = '0;
                    status_next    = rtmc_pkg::ST_OK;
                    count_next     = 6'd0;
                    req_valid_next = 1'b0;
                    req_next       = '0;
                end
            end
            rtmc_pkg::S_PUSH:
            begin
                if (item_reg.in_range)
                begin
                    if (cur_fill == FW'(FIFO_DEPTH))
                    begin
                        status_next = rtmc_pkg::ST_FULL;
                    end
                    else
                    begin
                        arm_we = 1'b1;
                        thr_we = 1'b1;
                        fill_n = cur_fill + 1'b1;
                    end
                end
            end
            rtmc_pkg::S_SCAN:
            begin
                if (!((item_reg.op == rtmc_pkg::OP_SCHED) ? cur_ready : (cur_fill != '0)) &&
                    !last_t)
                    t_next = t_reg + 1'b1;
            end
            rtmc_pkg::S_HEAD:
            begin
                if (item_reg.op == rtmc_pkg::OP_RESP)
                begin
                    if (arm_rdata[31:0] == item_reg.addr)
                    begin
                        thr_we     = 1'b1;
                        delay_n    = delay_sum[16] ? rtmc_pkg::DELAY_MAX : delay_sum[15:0];
                        head_n     = (32'(cur_head) == FIFO_DEPTH - 1) ? '0 : cur_head + 1'b1;
                        fill_n     = cur_fill - 1'b1;
                        mark_n     = 1'b0;
                        count_next = count_reg + 6'd1;
                    end
                    if (!last_t) t_next = t_reg + 1'b1;
                end
                else
                begin
                    pair_next = arm_rdata;
                    if (pfill_reg == '0)
                    begin
                        // empty queue: the pair is new
                        qrm_we     = 1'b1;
                        qrm_wdata  = arm_rdata;
                        pfill_next = pfill_reg + 1'b1;
                        thr_we     = 1'b1;
                        mark_n     = 1'b1;
                        if (!last_t) t_next = t_reg + 1'b1;
                    end
                    else
                    begin
                        q_idx_next = '0;
                    end
                end
            end
            rtmc_pkg::S_QCMP:
            begin
                qrm_raddr = qaddr(qhead_reg, q_idx_reg + 1'b1);
                if (qrm_rdata[47:0] == pair_reg[47:0])
                begin
                    thr_we = 1'b1;
                    mark_n = 1'b1;
                    if (!last_t) t_next = t_reg + 1'b1;
                end
                else if ((q_idx_reg + 1'b1) < pfill_reg)
                begin
                    q_idx_next = q_idx_reg + 1'b1;
                end
                else
                begin
                    if (pfill_reg != QFW'(QUEUE_DEPTH))
                    begin
                        qrm_we     = 1'b1;
                        pfill_next = pfill_reg + 1'b1;
                        thr_we     = 1'b1;
                        mark_n     = 1'b1;
                    end
                    else
                    begin
                        // full queue: head stays unmarked for a later retry
                        status_next = rtmc_pkg::ST_FULL;
                    end
                    if (!last_t) t_next = t_reg + 1'b1;
                end
            end
            rtmc_pkg::S_ISSUE:
            begin
                if (pfill_reg == '0 && status_reg == rtmc_pkg::ST_OK)
                    status_next = rtmc_pkg::ST_EMPTY;
            end
            rtmc_pkg::S_ISSUE_RD:
            begin
                req_valid_next = 1'b1;
                req_next       = qrm_rdata;
                qhead_next     = (32'(qhead_reg) == QUEUE_DEPTH - 1) ? '0 : qhead_reg + 1'b1;
                pfill_next     = pfill_reg - 1'b1;
            end
            rtmc_pkg::S_TICK:
            begin
                if (cur_delay != 16'd0)
                begin
                    thr_we     = 1'b1;
                    delay_n    = cur_delay - 16'd1;
                    count_next = count_reg + 6'd1;
                end
                if (!last_t) t_next = t_reg + 1'b1;
            end
            rtmc_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.req_valid    = req_valid_reg;
                    out_next.req_addr     = req_reg[31:0];
                    out_next.req_size     = req_reg[47:32];
                    out_next.req_kind     = req_reg[50:48];
                    out_next.thread_count = count_reg;
                    out_next.stalled      = (pfill_reg == '0) && (ready_cnt_reg == '0);
                    out_next.delays_done  = (busy_cnt_reg == '0);
                    out_next.active_count = 6'(active_cnt_reg);
                end
            end
            default:
            begin
            end
        endcase

        // summary counters follow the single thread touched this cycle
        active_cnt_next = active_cnt_reg;
        busy_cnt_next   = busy_cnt_reg;
        ready_cnt_next  = ready_cnt_reg;
        if (thr_we)
        begin
            active_cnt_next = active_cnt_reg + CW'(fill_n != '0) - CW'(cur_fill != '0);
            busy_cnt_next   = busy_cnt_reg + CW'(delay_n != 16'd0) - CW'(cur_delay != 16'd0);
            ready_cnt_next  = ready_cnt_reg +
                              CW'((fill_n != '0) && (delay_n == 16'd0) && !mark_n) -
                              CW'(cur_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pair_reg <= pair_next;
        req_reg  <= req_next;
        out_reg  <= out_next;
        q_idx_reg <= q_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtmc_pkg::S_IDLE;
            t_reg          <= '0;
            qhead_reg      <= '0;
            pfill_reg      <= '0;
            status_reg     <= rtmc_pkg::ST_OK;
            count_reg      <= 6'd0;
            req_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            active_cnt_reg <= '0;
            busy_cnt_reg   <= '0;
            ready_cnt_reg  <= '0;
            for (int i = 0; i < THREADS; i++)
            begin
                fill_reg[i]  <= '0;
                head_reg[i]  <= '0;
                delay_reg[i] <= '0;
                mark_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            t_reg          <= t_next;
            qhead_reg      <= qhead_next;
            pfill_reg      <= pfill_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            req_valid_reg  <= req_valid_next;
            out_valid_reg  <= out_valid_next;
            active_cnt_reg <= active_cnt_next;
            busy_cnt_reg   <= busy_cnt_next;
            ready_cnt_reg  <= ready_cnt_next;
            if (thr_we)
            begin
                fill_reg[cur]  <= fill_n;
                head_reg[cur]  <= head_n;
                delay_reg[cur] <= delay_n;
                mark_reg[cur]  <= mark_n;
            end
        end
    end

endmodule

[src/ray_traversal_mem_request_coalescer_unit.sv]
// ----------------------------------------------------------------------------
// ray_traversal_mem_request_coalescer_unit
// Per-thread traversal access FIFOs with a deduplicated pending request queue.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carry requests in; result/result_valid/
//   result_stall carry exactly one result per request out.
//   A request is taken when valid is high and stall is low.
//   Work per request:
//     push     writes the addressed thread's FIFO only
//     tick     visits every thread
//     response visits every thread, reading the head of each non-empty FIFO
//     schedule visits every thread, reads each ready head and compares it
//              with the pending entries, then issues the oldest entry
//   The back sequencer walks the threads one at a time and compares one
//   pending entry per cycle.
//   A two-entry request queue in front lets requests arrive while one runs.
//   Result register: when result_stall is high the result holds and the
//   sequencer waits before finishing the next request.
//   Reset empties every FIFO, zeroes the delays and the pending queue and
//   resets all four latency registers. No clearing pass is needed.
//   APB: registers at 0x0, 0x4, 0x8, 0xC; pready always high.
// ----------------------------------------------------------------------------
module ray_traversal_mem_request_coalescer_unit #(
    parameter int THREADS     = rtmc_pkg::THREADS_DEF,
    parameter int FIFO_DEPTH  = rtmc_pkg::FIFO_DEPTH_DEF,
    parameter int QUEUE_DEPTH = rtmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  rtmc_pkg::in_req_t              item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output rtmc_pkg::out_rsp_t             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtmc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [7:0]      lat_reg [rtmc_pkg::CFG_REGS];
    logic            cfg_wr;
    rtmc_pkg::cfg_t  cfg;
    logic            work_valid;
    logic            work_take;
    rtmc_pkg::work_t work;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {24'd0, lat_reg[paddr[3:2]]};

    assign cfg.internal_lat = lat_reg[rtmc_pkg::REG_INTERNAL];
    assign cfg.instance_lat = lat_reg[rtmc_pkg::REG_INSTANCE];
    assign cfg.quad_lat     = lat_reg[rtmc_pkg::REG_QUAD];
    assign cfg.quad_hit_lat = lat_reg[rtmc_pkg::REG_QUAD_HIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtmc_pkg::CFG_REGS; i++)
            begin
                lat_reg[i] <= 8'd1;
            end
        end
        else if (cfg_wr)
        begin
            lat_reg[paddr[3:2]] <= pwdata[7:0];
        end
    end

    // front: take and decode requests
    rtmc_front #(.THREADS(THREADS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .work_valid (work_valid),
        .work_take  (work_take),
        .work       (work)
    );

    // back: thread walk, FIFO and pending queue memories, result register
    rtmc_back #(
        .THREADS     (THREADS),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .work_valid   (work_valid),
        .work_take    (work_take),
        .work         (work),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[bench/ray_traversal_mem_request_coalescer_unit_test.sv]
// ----------------------------------------------------------------------------
// ray_traversal_mem_request_coalescer_unit_test
// Self-checking bench: random and directed requests against a behavioral
// predictor of the per-thread access FIFOs and the pending request queue.
// ----------------------------------------------------------------------------
module ray_traversal_mem_request_coalescer_unit_test;

    localparam int NT = rtmc_pkg::THREADS_DEF;
    localparam int FD = rtmc_pkg::FIFO_DEPTH_DEF;
    localparam int QD = rtmc_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 5000000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    rtmc_pkg::in_req_t item;
    logic result_valid;
    logic result_stall;
    rtmc_pkg::out_rsp_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [rtmc_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ray_traversal_mem_request_coalescer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    typedef struct packed {
        logic        marked;
        logic [2:0]  kind;
        logic [15:0] size;
        logic [31:0] addr;
    } access_t;

    access_t         fifo_mem [NT][FD];
    int              fill [NT];
    int              head [NT];
    int              delay [NT];
    logic [50:0]     pend_q [$];
    rtmc_pkg::cfg_t  lat_cfg;

    rtmc_pkg::in_req_t  req_pending [$];    // requests waiting for the driver
    rtmc_pkg::out_rsp_t rsp_expected [$];   // predicted results, oldest first
    int       errors = 0;
    int       cycles = 0;
    int       sent = 0;
    int       got = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_recv = 1'b0;   // long receiver hold-off, fills the block

    function automatic int lat_of(input logic [2:0] k);
        case (k)
            rtmc_pkg::KIND_INTERNAL: return int'(lat_cfg.internal_lat);
            rtmc_pkg::KIND_INSTANCE: return int'(lat_cfg.instance_lat);
            rtmc_pkg::KIND_QUAD:     return int'(lat_cfg.quad_lat);
            rtmc_pkg::KIND_QUAD_HIT: return int'(lat_cfg.quad_hit_lat);
            default:                 return 1;
        endcase
    endfunction

    function automatic logic head_ready(input int t);
        return fill[t] != 0 && delay[t] == 0 && !fifo_mem[t][head[t]].marked;
    endfunction

    // Work out the result of one accepted request and advance the state.
    function automatic rtmc_pkg::out_rsp_t coalesce_step(input rtmc_pkg::in_req_t r);
        rtmc_pkg::out_rsp_t o;
        int cnt;
        int act;
        int slot;
        int d;
        logic hit;
        logic [50:0] pair;
        o = '0;
        cnt = 0;
        act = 0;
        case (rtmc_pkg::op_t'(r.action))
            rtmc_pkg::OP_PUSH:
            begin
                if (fill[r.thread] >= FD)
                    o.status = rtmc_pkg::ST_FULL;
                else
                begin
                    slot = (head[r.thread] + fill[r.thread]) % FD;
                    fifo_mem[r.thread][slot] = {1'b0, r.kind, r.size, r.addr};
                    fill[r.thread]++;
                end
            end
            rtmc_pkg::OP_SCHED:
            begin
                for (int t = 0; t < NT; t++)
                begin
                    if (head_ready(t))
                    begin
                        pair = fifo_mem[t][head[t]][50:0];
                        hit = 1'b0;
                        // dedupe compares address and size only
                        foreach (pend_q[i])
                            if (pend_q[i][47:0] == pair[47:0])
                                hit = 1'b1;
                        if (hit)
                            fifo_mem[t][head[t]].marked = 1'b1;
                        else if (pend_q.size() < QD)
                        begin
                            pend_q = {pend_q, pair};
                            fifo_mem[t][head[t]].marked = 1'b1;
                        end
                        else
                            o.status = rtmc_pkg::ST_FULL;
                    end
                end
                if (pend_q.size() == 0)
                begin
                    if (o.status == rtmc_pkg::ST_OK)
                        o.status = rtmc_pkg::ST_EMPTY;
                end
                else
                begin
                    pair = pend_q[0];
                    pend_q.delete(0);
                    o.req_valid = 1'b1;
                    o.req_addr = pair[31:0];
                    o.req_size = pair[47:32];
                    o.req_kind = pair[50:48];
                end
            end
            rtmc_pkg::OP_RESP:
            begin
                for (int t = 0; t < NT; t++)
                begin
                    if (fill[t] != 0 && fifo_mem[t][head[t]].addr == r.addr)
                    begin
                        d = delay[t] + lat_of(fifo_mem[t][head[t]].kind);
                        delay[t] = (d > 65535) ? 65535 : d;
                        head[t] = (head[t] + 1) % FD;
                        fill[t]--;
                        cnt++;
                    end
                end
            end
            default:
            begin
                for (int t = 0; t < NT; t++)
                    if (delay[t] != 0)
                    begin
                        delay[t]--;
                        cnt++;
                    end
            end
        endcase
        o.thread_count = 6'(cnt);
        o.stalled = (pend_q.size() == 0);
        o.delays_done = 1'b1;
        for (int t = 0; t < NT; t++)
        begin
            if (head_ready(t)) o.stalled = 1'b0;
            if (delay[t] != 0) o.delays_done = 1'b0;
            if (fill[t] != 0) act++;
        end
        o.active_count = 6'(act);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint exp_v);
        errors++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", got, what, got_v, exp_v);
    endtask

    // Driver: offers the next queued request; payload holds while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || !item_stall)
            begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= req_pending[0];
                    rsp_expected = {rsp_expected, coalesce_step(req_pending[0])};
                    req_pending.delete(0);
                    item_valid <= 1'b1;
                    sent++;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver stall and result check.
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    rtmc_pkg::out_rsp_t e;
                    e = rsp_expected[0];
                    rsp_expected.delete(0);
                    if (result.status != e.status)
                        report_mismatch("status", longint'(result.status),
                                        longint'(e.status));
                    if (result.req_valid != e.req_valid)
                        report_mismatch("req_valid", longint'(result.req_valid),
                                        longint'(e.req_valid));
                    if (result.req_addr != e.req_addr)
                        report_mismatch("req_addr", longint'(result.req_addr),
                                        longint'(e.req_addr));
                    if (result.req_size != e.req_size)
                        report_mismatch("req_size", longint'(result.req_size),
                                        longint'(e.req_size));
                    if (result.req_kind != e.req_kind)
                        report_mismatch("req_kind", longint'(result.req_kind),
                                        longint'(e.req_kind));
                    if (result.thread_count != e.thread_count)
                        report_mismatch("thread_count", longint'(result.thread_count),
                                        longint'(e.thread_count));
                    if (result.stalled != e.stalled)
                        report_mismatch("stalled", longint'(result.stalled),
                                        longint'(e.stalled));
                    if (result.delays_done != e.delays_done)
                        report_mismatch("delays_done", longint'(result.delays_done),
                                        longint'(e.delays_done));
                    if (result.active_count != e.active_count)
                        report_mismatch("active_count", longint'(result.active_count),
                                        longint'(e.active_count));
                end
                got++;
            end
            result_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= rtmc_pkg::PADDR_W'({idx, 2'b00}); pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rtmc_pkg::REG_INTERNAL: lat_cfg.internal_lat = val;
            rtmc_pkg::REG_INSTANCE: lat_cfg.instance_lat = val;
            rtmc_pkg::REG_QUAD:     lat_cfg.quad_lat = val;
            default:                lat_cfg.quad_hit_lat = val;
        endcase
    endtask

    // Wait until queued requests are taken and all results are back, then let
    // the block finish any internal work.
    task automatic drain;
        while (req_pending.size() != 0 || rsp_expected.size() != 0 || item_valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic rtmc_pkg::in_req_t mk(input rtmc_pkg::op_t op, input logic [4:0] th,
                                             input logic [31:0] a, input logic [15:0] s,
                                             input logic [2:0] k);
        rtmc_pkg::in_req_t r;
        r.action = op; r.thread = th; r.addr = a; r.size = s; r.kind = k;
        return r;
    endfunction

    task automatic queue_req(input rtmc_pkg::in_req_t r);
        req_pending = {req_pending, r};
    endtask

    // Random phase: mostly well-formed push/schedule/response/tick rounds using
    // a small address pool so coalescing and multi-thread matches happen.
    task automatic random_round(input int n);
        logic [31:0] pool [8];
        logic [15:0] spool [8];
        for (int i = 0; i < 8; i++)
        begin
            pool[i] = $urandom();
            spool[i] = $urandom_range(3) == 0 ? 16'($urandom()) : 16'(64 << $urandom_range(3));
        end
        for (int i = 0; i < n; i++)
        begin
            int p;
            int j;
            p = $urandom_range(99);
            j = $urandom_range(7);
            if (p < 40)
                queue_req(mk(rtmc_pkg::OP_PUSH, 5'($urandom()), pool[j], spool[j],
                             3'($urandom())));
            else if (p < 60)
                queue_req(mk(rtmc_pkg::OP_SCHED, 5'($urandom()), $urandom(),
                             16'($urandom()), 3'($urandom())));
            else if (p < 80)
                queue_req(mk(rtmc_pkg::OP_RESP, 5'($urandom()),
                             ($urandom_range(9) == 0) ? $urandom() : pool[j],
                             16'($urandom()), 3'($urandom())));
            else
                queue_req(mk(rtmc_pkg::OP_TICK, 5'($urandom()), $urandom(),
                             16'($urandom()), 3'($urandom())));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0; item = '0; result_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        lat_cfg = {8'd1, 8'd1, 8'd1, 8'd1};
        for (int t = 0; t < NT; t++)
        begin
            fill[t] = 0; head[t] = 0; delay[t] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty schedule, full FIFO, dedupe, all kinds, all-ones fields,
        // and the largest and zero latency settings.
        cfg_write(rtmc_pkg::REG_INTERNAL, 8'd255);
        cfg_write(rtmc_pkg::REG_INSTANCE, 8'd0);
        cfg_write(rtmc_pkg::REG_QUAD, 8'd7);
        cfg_write(rtmc_pkg::REG_QUAD_HIT, 8'd255);
        queue_req(mk(rtmc_pkg::OP_SCHED, 5'd0, 32'd0, 16'd0, 3'd0));
        queue_req(mk(rtmc_pkg::OP_TICK, 5'd0, 32'd0, 16'd0, 3'd0));
        for (int i = 0; i < 17; i++)
            queue_req(mk(rtmc_pkg::OP_PUSH, 5'd31, 32'hFFFF_FFFF, 16'hFFFF, 3'(i)));
        queue_req(mk(rtmc_pkg::OP_PUSH, 5'd0, 32'hFFFF_FFFF, 16'hFFFF,
                     rtmc_pkg::KIND_QUAD_HIT));
        queue_req(mk(rtmc_pkg::OP_SCHED, 5'd0, 32'd0, 16'd0, 3'd0));
        queue_req(mk(rtmc_pkg::OP_RESP, 5'd0, 32'hFFFF_FFFF, 16'd0, 3'd0));
        queue_req(mk(rtmc_pkg::OP_TICK, 5'd0, 32'd0, 16'd0, 3'd0));
        queue_req(mk(rtmc_pkg::OP_RESP, 5'd0, 32'h1234, 16'd0, 3'd0));
        drain();
        // drain the thread-31 FIFO, then build up large delays with internal-kind hits
        for (int i = 0; i < 16; i++)
            queue_req(mk(rtmc_pkg::OP_RESP, 5'd0, 32'hFFFF_FFFF, 16'd0, 3'd0));
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < 16; i++)
                queue_req(mk(rtmc_pkg::OP_PUSH, 5'(k), 32'h100, 16'd0,
                             rtmc_pkg::KIND_INTERNAL));
            for (int i = 0; i < 16; i++)
                queue_req(mk(rtmc_pkg::OP_RESP, 5'd0, 32'h100, 16'd0, 3'd0));
        end
        // pending queue: 32 distinct heads pushed, then two schedules
        for (int t = 0; t < NT; t++)
            queue_req(mk(rtmc_pkg::OP_PUSH, 5'(t), 32'(t * 16), 16'(t), 3'(t)));
        queue_req(mk(rtmc_pkg::OP_SCHED, 5'd0, 32'd0, 16'd0, 3'd0));
        queue_req(mk(rtmc_pkg::OP_SCHED, 5'd0, 32'd0, 16'd0, 3'd0));
        drain();

        // Random phases with different latency settings and idling mixes.
        cfg_write(rtmc_pkg::REG_INTERNAL, 8'd0);
        cfg_write(rtmc_pkg::REG_INSTANCE, 8'd255);
        cfg_write(rtmc_pkg::REG_QUAD, 8'd0);
        cfg_write(rtmc_pkg::REG_QUAD_HIT, 8'd3);
        send_idle_pct = 11; recv_idle_pct = 63;
        random_round(110);
        drain();

        cfg_write(rtmc_pkg::REG_INTERNAL, 8'd2);
        cfg_write(rtmc_pkg::REG_INSTANCE, 8'd1);
        cfg_write(rtmc_pkg::REG_QUAD, 8'd255);
        cfg_write(rtmc_pkg::REG_QUAD_HIT, 8'd0);
        send_idle_pct = 63; recv_idle_pct = 11;
        random_round(100);
        drain();

        // No idling; receiver holds off long enough that the input side backs up.
        send_idle_pct = 0; recv_idle_pct = 0;
        random_round(110);
        hold_recv = 1'b1;
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
        drain();

        $display("Covered %0d requests, %0d results: pushes, schedules, responses, ticks",
                 sent, got);
        $display("under three latency settings, full FIFO/queue and long receiver hold-off.");
        if (errors == 0)
            $display("ray_traversal_mem_request_coalescer_unit test passed");
        else
            $display("ray_traversal_mem_request_coalescer_unit test failed");
        $finish;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ray_traversal_mem_request_coalescer_unit test failed");
            $finish;
        end
    end

endmodule

[files.f]
src/rtmc_pkg.sv
src/rtmc_ram.sv
src/rtmc_front.sv
src/rtmc_back.sv
src/ray_traversal_mem_request_coalescer_unit.sv
bench/ray_traversal_mem_request_coalescer_unit_test.sv
